// File: src/psp_pkg.sv
`default_nettype none
package psp_pkg;

    localparam int POS_W = 36;
    localparam int LEN_W = 17;
    localparam int NOTES = 128;
    localparam int DEF_VOICES = 128;
    localparam int DEF_SAMPLE_WORDS = 65536;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_MIDI   = 2'd1;
    localparam logic [1:0] MODE_BEGIN  = 2'd2;
    localparam logic [1:0] MODE_APPEND = 2'd3;

    localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
    localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;

    localparam logic CFG_REPEAT = 1'b0;
    localparam logic CFG_PITCH  = 1'b1;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] num;
        logic [POS_W-1:0] den;
    } psp_mod_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [POS_W-1:0] rem;
    } psp_mod_rsp_t;

    // 12.16 step 2^(note/12), shifted down to frac fraction bits
    function automatic logic [POS_W-1:0] pitch_step(input logic [6:0] note, input int frac);
        logic [3:0]       oct;
        logic [6:0]       semi;
        logic [16:0]      base;
        logic [POS_W-1:0] wide;
        oct = 4'd0;
        for (int i = 1; i <= 10; i++) begin
            if (note >= 7'(12 * i)) oct = 4'(i);
        end
        semi = note - 7'(12 * oct);
        case (semi[3:0])
            4'd0:    base = 17'd65536;
            4'd1:    base = 17'd69433;
            4'd2:    base = 17'd73562;
            4'd3:    base = 17'd77936;
            4'd4:    base = 17'd82570;
            4'd5:    base = 17'd87480;
            4'd6:    base = 17'd92682;
            4'd7:    base = 17'd98193;
            4'd8:    base = 17'd104032;
            4'd9:    base = 17'd110218;
            4'd10:   base = 17'd116772;
            4'd11:   base = 17'd123715;
            default: base = 17'd65536;
        endcase
        wide = POS_W'(base) << oct;
        return wide >> (16 - frac);
    endfunction

endpackage
`default_nettype wire

// File: src/psp_ram.sv
`default_nettype none
module psp_ram #(
    parameter int W = 16,
    parameter int D = 256,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: src/psp_mod.sv
`default_nettype none
module psp_mod #(
    parameter int FRAC_BITS = psp_pkg::DEF_FRAC_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire psp_pkg::psp_mod_req_t req,
    output psp_pkg::psp_mod_rsp_t     rsp
);
    import psp_pkg::*;

    // restoring remainder, one quotient bit per cycle
    localparam int STEPS = POS_W - FRAC_BITS;
    localparam int KW = $clog2(STEPS);

    logic             busy_reg, done_reg;
    logic [KW-1:0]    k_reg;
    logic [POS_W-1:0] rem_reg, den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                rem_reg  <= req.num;
                den_reg  <= req.den;
                k_reg    <= KW'(STEPS - 1);
            end else if (busy_reg) begin
                if ((rem_reg >> k_reg) >= den_reg) rem_reg <= rem_reg - (den_reg << k_reg);
                if (k_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    k_reg <= k_reg - 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;
endmodule
`default_nettype wire

// File: src/polyphonic_sample_player.sv
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata midi and load fields
// m_      | out | m_tvalid/m_tready  | m_tdata mix, active_voices
// cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata
// Midi and begin items end in idle; an append also uses ST_AP (SAMPLE_WORDS is a power of two).
// A tick scans every voice; per active voice an empty sound is released, otherwise the
// position is reduced by the shared remainder unit to read a sample, and a second
// remainder pass runs when repeat mode wraps the position.
// Synchronous active-low reset clears voice and length valid bits at once; no clearing pass.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
module polyphonic_sample_player #(
    parameter int VOICES       = psp_pkg::DEF_VOICES,
    parameter int SAMPLE_WORDS = psp_pkg::DEF_SAMPLE_WORDS,
    parameter int FRAC_BITS    = psp_pkg::DEF_FRAC_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // midi_status, midi_data_one, midi_data_two, midi_length, load_note, load_base,
    // sample_value
    input  wire logic [63:0] s_tdata,
    // mode
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // mix, active_voices
    output logic      [39:0] m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic        cfg_wdata
);
    import psp_pkg::*;

    localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VCW = $clog2(VOICES + 1);
    localparam int SAW = $clog2(SAMPLE_WORDS);
    localparam int VDW = 7 + POS_W;
    localparam int SDW = 16 + LEN_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SCAN = 4'd1;
    localparam logic [3:0] ST_RD   = 4'd2;
    localparam logic [3:0] ST_CHK  = 4'd3;
    localparam logic [3:0] ST_M1   = 4'd4;
    localparam logic [3:0] ST_M2   = 4'd5;
    localparam logic [3:0] ST_SR   = 4'd6;
    localparam logic [3:0] ST_ACC  = 4'd7;
    localparam logic [3:0] ST_M3   = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;
    localparam logic [3:0] ST_AP   = 4'd10;

    logic [7:0]  f_status;
    logic [6:0]  f_d1, f_d2, f_lnote;
    logic [1:0]  f_len;
    logic [15:0] f_base, f_sample;
    assign f_status = s_tdata[7:0];
    assign f_d1     = s_tdata[14:8];
    assign f_d2     = s_tdata[21:15];
    assign f_len    = s_tdata[23:22];
    assign f_lnote  = s_tdata[30:24];
    assign f_base   = s_tdata[46:31];
    assign f_sample = s_tdata[62:47];

    logic [3:0]        state_reg;
    logic [VCW-1:0]    v_reg;
    logic [VOICES-1:0] active_reg;
    logic [NOTES-1:0]  len_vld_reg;
    logic              repeat_reg, pitch_reg;
    logic [7:0]        extent_reg;
    logic [6:0]        lnote_reg;
    logic [15:0]       cur_start_reg, sample_in_reg;
    logic [LEN_W-1:0]  cur_len_reg;
    logic [POS_W-1:0]  pos_reg, newpos_reg;
    logic [6:0]        vel_reg;
    logic [15:0]       start_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SAW-1:0]    addr_reg;
    logic              rd_ok_reg;
    logic signed [23:0] prod_reg;
    logic [30:0]       acc_reg, m_mix_reg;
    logic [7:0]        cnt_reg, m_cnt_reg;
    logic              m_valid_reg;

    logic [VW-1:0]     vidx;
    logic [6:0]        snd;
    assign vidx = v_reg[VW-1:0];
    assign snd  = pitch_reg ? 7'd0 : 7'(vidx);

    logic accept;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // midi decode
    logic note_ok, midi_off, midi_on;
    assign note_ok  = {1'b0, f_d1} < 8'(VOICES);
    assign midi_off = (f_status[7:4] == MIDI_NOTE_OFF && f_len >= 2'd2 && note_ok) ||
                      (f_status[7:4] == MIDI_NOTE_ON && f_len == 2'd3 && note_ok &&
                       f_d2 == 7'd0);
    assign midi_on  = f_status[7:4] == MIDI_NOTE_ON && f_len == 2'd3 && note_ok &&
                      f_d2 != 7'd0 && (pitch_reg || {1'b0, f_d1} < extent_reg);

    // memories
    logic             vr_we;
    logic [VW-1:0]    vr_waddr;
    logic [VDW-1:0]   vr_wdata, vr_rdata;
    logic             sr_we;
    logic [6:0]       sr_waddr;
    logic [SDW-1:0]   sr_wdata, sr_rdata;
    logic             sm_we;
    logic [SAW-1:0]   sm_raddr;
    logic [15:0]      sm_rdata;

    psp_ram #(.W(VDW), .D(VOICES)) u_voice_ram (
        .aclk(aclk), .we(vr_we), .waddr(vr_waddr), .wdata(vr_wdata),
        .raddr(vidx), .rdata(vr_rdata)
    );
    psp_ram #(.W(SDW), .D(NOTES)) u_sound_ram (
        .aclk(aclk), .we(sr_we), .waddr(sr_waddr), .wdata(sr_wdata),
        .raddr(snd), .rdata(sr_rdata)
    );

    psp_mod_req_t mod_req;
    psp_mod_rsp_t mod_rsp;
    psp_mod #(.FRAC_BITS(FRAC_BITS)) u_mod (
        .aclk(aclk), .aresetn(aresetn), .req(mod_req), .rsp(mod_rsp)
    );

    psp_ram #(.W(16), .D(SAMPLE_WORDS)) u_sample_ram (
        .aclk(aclk), .we(sm_we), .waddr(addr_reg), .wdata(sample_in_reg),
        .raddr(sm_raddr), .rdata(sm_rdata)
    );
    assign sm_raddr = addr_reg;
    assign sm_we    = (state_reg == ST_AP);

    logic [POS_W-1:0] span, inc, pos_int;
    logic [LEN_W-1:0] idx;
    logic             can_load;
    assign span     = POS_W'(len_reg) << FRAC_BITS;
    assign inc      = pitch_reg ? pitch_step(7'(vidx), FRAC_BITS) : (POS_W'(1) << FRAC_BITS);
    assign pos_int  = (pos_reg >> FRAC_BITS) << FRAC_BITS;
    assign idx      = LEN_W'(mod_rsp.rem >> FRAC_BITS);
    assign can_load = !m_valid_reg || m_tready;

    always_comb begin
        mod_req = '0;
        vr_we = 1'b0;
        vr_waddr = vidx;
        vr_wdata = {vel_reg, pos_reg};
        sr_we = 1'b0;
        sr_waddr = lnote_reg;
        sr_wdata = {cur_start_reg, cur_len_reg + 1'b1};
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == MODE_MIDI && midi_on) begin
                    vr_we = 1'b1;
                    vr_waddr = f_d1[VW-1:0];
                    vr_wdata = {f_d2, {POS_W{1'b0}}};
                end
                if (accept && s_tuser == MODE_BEGIN) begin
                    sr_we = 1'b1;
                    sr_waddr = f_lnote;
                    sr_wdata = {f_base, {LEN_W{1'b0}}};
                end
            end
            ST_CHK: begin
                if (len_reg != '0) begin
                    mod_req.start = 1'b1;
                    mod_req.num = pos_int;
                    mod_req.den = span;
                end
            end
            ST_ACC: begin
                if (newpos_reg >= span && repeat_reg) begin
                    mod_req.start = 1'b1;
                    mod_req.num = newpos_reg;
                    mod_req.den = span;
                end else begin
                    vr_we = 1'b1;
                    vr_wdata = {vel_reg, newpos_reg};
                end
            end
            ST_M3: begin
                if (mod_rsp.done) begin
                    vr_we = 1'b1;
                    vr_wdata = {vel_reg, mod_rsp.rem};
                end
            end
            ST_AP: begin
                sr_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            v_reg       <= '0;
            active_reg  <= '0;
            len_vld_reg <= '0;
            repeat_reg  <= 1'b0;
            pitch_reg   <= 1'b0;
            extent_reg  <= '0;
            lnote_reg   <= '0;
            cur_len_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_REPEAT) repeat_reg <= cfg_wdata;
                if (cfg_index == CFG_PITCH)  pitch_reg  <= cfg_wdata;
            end
            if (m_valid_reg && m_tready && state_reg != ST_DONE) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_tuser)
                            MODE_TICK: begin
                                v_reg     <= '0;
                                acc_reg   <= '0;
                                cnt_reg   <= '0;
                                state_reg <= ST_SCAN;
                            end
                            MODE_MIDI: begin
                                if (midi_off) active_reg[f_d1[VW-1:0]] <= 1'b0;
                                if (midi_on)  active_reg[f_d1[VW-1:0]] <= 1'b1;
                            end
                            MODE_BEGIN: begin
                                lnote_reg     <= f_lnote;
                                cur_start_reg <= f_base;
                                cur_len_reg   <= '0;
                                len_vld_reg[f_lnote] <= 1'b1;
                                if (extent_reg < {1'b0, f_lnote} + 8'd1)
                                    extent_reg <= {1'b0, f_lnote} + 8'd1;
                            end
                            default: begin
                                sample_in_reg <= f_sample;
                                addr_reg <= SAW'(18'(cur_start_reg) + 18'(cur_len_reg));
                                if (cur_len_reg < LEN_W'(SAMPLE_WORDS)) state_reg <= ST_AP;
                            end
                        endcase
                    end
                end
                ST_AP: begin
                    cur_len_reg <= cur_len_reg + 1'b1;
                    len_vld_reg[lnote_reg] <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (v_reg == VCW'(VOICES)) begin
                        state_reg <= ST_DONE;
                    end else if (active_reg[vidx]) begin
                        state_reg <= ST_RD;
                    end else begin
                        v_reg <= v_reg + 1'b1;
                    end
                end
                ST_RD: begin
                    pos_reg   <= vr_rdata[POS_W-1:0];
                    vel_reg   <= vr_rdata[VDW-1:POS_W];
                    start_reg <= sr_rdata[SDW-1:LEN_W];
                    len_reg   <= len_vld_reg[snd] ? sr_rdata[LEN_W-1:0] : '0;
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    if (len_reg == '0) begin
                        active_reg[vidx] <= 1'b0;
                        v_reg <= v_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end else begin
                        state_reg <= ST_M1;
                    end
                end
                ST_M1: begin
                    if (mod_rsp.done) begin
                        rd_ok_reg <= pitch_reg || repeat_reg ||
                                     ((pos_reg >> FRAC_BITS) < POS_W'(len_reg));
                        addr_reg  <= SAW'(18'(start_reg) + 18'(idx));
                        state_reg <= ST_M2;
                    end
                end
                ST_M2: begin
                    state_reg <= ST_SR;
                end
                ST_SR: begin
                    prod_reg   <= $signed(sm_rdata) * $signed({1'b0, vel_reg});
                    newpos_reg <= pos_reg + inc;
                    state_reg  <= ST_ACC;
                end
                ST_ACC: begin
                    if (rd_ok_reg) acc_reg <= acc_reg + 31'(prod_reg);
                    if (newpos_reg >= span && repeat_reg) begin
                        state_reg <= ST_M3;
                    end else begin
                        if (newpos_reg >= span) active_reg[vidx] <= 1'b0;
                        else cnt_reg <= cnt_reg + 1'b1;
                        v_reg <= v_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_M3: begin
                    if (mod_rsp.done) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        v_reg <= v_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_DONE: begin
                    if (can_load) begin
                        m_valid_reg <= 1'b1;
                        m_mix_reg   <= acc_reg;
                        m_cnt_reg   <= cnt_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_cnt_reg, m_mix_reg};
endmodule
`default_nettype wire

// File: src/psp_checker.sv
`default_nettype none
module psp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);
    import psp_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item dropped or changed while stalled");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == MODE_TICK |=> !s_tready)
        else $error("ready right after a tick item");

    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != MODE_TICK |=> !$rose(m_tvalid))
        else $error("result from a non-tick item");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[38:31] <= 8'd128 && !m_tdata[39])
        else $error("active voice count out of range");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind polyphonic_sample_player psp_checker u_psp_checker (.*);
`default_nettype wire
